// ----- sv/tsbs_pkg.sv -----
// Types and constants shared by the triangle scan and shade block.
`timescale 1ns / 1ps
`default_nettype none
package tsbs_pkg;

   localparam int COORD_W   = 11;  // pixel and vertex coordinate
   localparam int BOX_W     = 12;  // exclusive box bound, holds the screen size
   localparam int DIFF_W    = 12;  // signed coordinate difference
   localparam int AREA_W    = 25;  // signed doubled triangle area
   localparam int MULA_W    = 25;
   localparam int MULB_W    = 13;
   localparam int ACC_W     = 34;  // multiply-accumulate width
   localparam int NUM_W     = 32;  // colour-weighted numerator
   localparam int DEN_W     = 24;  // area magnitude
   localparam int QUO_W     = 8;   // one channel quotient
   localparam int DSR_W     = DEN_W + QUO_W - 1;
   localparam int VTX_W     = 22;
   localparam int COL_W     = 24;
   localparam int PIXCOL_W  = 25;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;
   localparam int STEP_W    = 3;
   localparam int CHAN_W    = 2;

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_A = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_B = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_C = 3'd5;

   // Colour channel order inside a packed colour
   localparam logic [CHAN_W-1:0] CHAN_RED   = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_GREEN = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_BLUE  = 2'd2;

   // Area sequencer selects: total area first, then the three pixel weights
   localparam logic [1:0] AREA_TOTAL = 2'd0;
   localparam logic [1:0] AREA_W0    = 2'd1;
   localparam logic [1:0] AREA_W1    = 2'd2;
   localparam logic [1:0] AREA_W2    = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_AREA   = 5'b00010,
      ST_MAC    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage
`default_nettype wire

// ----- sv/triangle_scan_barycentric_shade_top.sv -----
// Triangle bounding-box scan with barycentric colour interpolation.
//
// Usage: write the three vertices and three vertex colours through the csr_
// port while the block is idle. A req_ transaction with req_restart = 1
// clamps the triangle's bounding box to the screen (half-open) and reports
// its first pixel; each req_ transaction with req_restart = 0 reports the
// next pixel in row-major order. Every request yields exactly one rsp_
// transaction; rsp_valid_res = 0 marks an empty box or an advance with no
// scan running, and then all other fields are zero.
// Flow: one request is processed at a time. A pixel first computes its total
// and three weight areas through one shared multiplier, then for a covered
// pixel three channels of multiply-accumulate, each followed by bit-serial
// restoring division into an 8-bit quotient (one quotient bit per cycle).
// The result register lets the next request be accepted and worked on while
// a result waits; a stalled receiver only holds the block once a second
// result is ready. Reset clears the registers, the scan and the response
// valid flag.
`timescale 1ns / 1ps
`default_nettype none
module triangle_scan_barycentric_shade_top #(
   parameter int SCREEN_WIDTH  = 1024,
   parameter int SCREEN_HEIGHT = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_restart,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid_res,
   output logic [tsbs_pkg::COORD_W-1:0]             rsp_pixel_x,
   output logic [tsbs_pkg::COORD_W-1:0]             rsp_pixel_y,
   output logic                                     rsp_covered,
   output logic [tsbs_pkg::PIXCOL_W-1:0]            rsp_pixel_colour,
   output logic                                     rsp_last,
   input  wire logic                                csr_wr_en,
   input  wire logic [tsbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tsbs_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   localparam logic [tsbs_pkg::BOX_W-1:0] SW = tsbs_pkg::BOX_W'(SCREEN_WIDTH);
   localparam logic [tsbs_pkg::BOX_W-1:0] SH = tsbs_pkg::BOX_W'(SCREEN_HEIGHT);
   localparam int C = tsbs_pkg::COORD_W;

   // configuration
   logic [tsbs_pkg::VTX_W-1:0] vertex_ff [3];
   logic [tsbs_pkg::COL_W-1:0] colour_ff [3];

   // control
   tsbs_pkg::state_type state_ff, state_in;
   logic [tsbs_pkg::STEP_W-1:0] step_ff, step_in;
   logic [tsbs_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic                        active_ff, active_in;
   logic [C-1:0]                cursor_x_ff, cursor_x_in;
   logic [C-1:0]                cursor_y_ff, cursor_y_in;
   logic [C-1:0]                box_left_ff, box_left_in;
   logic [tsbs_pkg::BOX_W-1:0]  box_right_ff, box_right_in;
   logic [tsbs_pkg::BOX_W-1:0]  box_bottom_ff, box_bottom_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // datapath
   logic                                 pix_ok_ff, pix_ok_in;
   logic                                 cov_ff, cov_in;
   logic                                 t_neg_ff, t_neg_in;
   logic signed [tsbs_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [tsbs_pkg::AREA_W-1:0]   area_ff [4];
   logic signed [tsbs_pkg::AREA_W-1:0]   area_in [4];
   logic [tsbs_pkg::NUM_W-1:0]           rem_ff, rem_in;
   logic [tsbs_pkg::DSR_W-1:0]           dsr_ff, dsr_in;
   logic [tsbs_pkg::QUO_W-1:0]           quo_ff, quo_in;
   logic [tsbs_pkg::COL_W-1:0]           shade_ff, shade_in;

   // result register
   logic                            res_valid_ff, res_valid_in;
   logic [C-1:0]                    res_x_ff, res_x_in;
   logic [C-1:0]                    res_y_ff, res_y_in;
   logic                            res_cov_ff, res_cov_in;
   logic [tsbs_pkg::PIXCOL_W-1:0]   res_col_ff, res_col_in;
   logic                            res_last_ff, res_last_in;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vertex_ff[i] <= '0;
            colour_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tsbs_pkg::REG_VERTEX_A: vertex_ff[0] <= csr_wdata[tsbs_pkg::VTX_W-1:0];
            tsbs_pkg::REG_VERTEX_B: vertex_ff[1] <= csr_wdata[tsbs_pkg::VTX_W-1:0];
            tsbs_pkg::REG_VERTEX_C: vertex_ff[2] <= csr_wdata[tsbs_pkg::VTX_W-1:0];
            tsbs_pkg::REG_COLOUR_A: colour_ff[0] <= csr_wdata;
            tsbs_pkg::REG_COLOUR_B: colour_ff[1] <= csr_wdata;
            tsbs_pkg::REG_COLOUR_C: colour_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- bounding box
   logic [C-1:0] ax, ay, bx, by, cx, cy;
   assign ax = vertex_ff[0][C-1:0];
   assign ay = vertex_ff[0][2*C-1:C];
   assign bx = vertex_ff[1][C-1:0];
   assign by = vertex_ff[1][2*C-1:C];
   assign cx = vertex_ff[2][C-1:0];
   assign cy = vertex_ff[2][2*C-1:C];

   logic [tsbs_pkg::BOX_W-1:0] xmin, ymin, xmax, ymax, xmax_raw, ymax_raw;
   logic                       box_empty;

   always_comb begin
      xmin = SW;
      ymin = SH;
      xmax_raw = '0;
      ymax_raw = '0;
      if ({1'b0, ax} < xmin) xmin = {1'b0, ax};
      if ({1'b0, bx} < xmin) xmin = {1'b0, bx};
      if ({1'b0, cx} < xmin) xmin = {1'b0, cx};
      if ({1'b0, ay} < ymin) ymin = {1'b0, ay};
      if ({1'b0, by} < ymin) ymin = {1'b0, by};
      if ({1'b0, cy} < ymin) ymin = {1'b0, cy};
      if ({1'b0, ax} > xmax_raw) xmax_raw = {1'b0, ax};
      if ({1'b0, bx} > xmax_raw) xmax_raw = {1'b0, bx};
      if ({1'b0, cx} > xmax_raw) xmax_raw = {1'b0, cx};
      if ({1'b0, ay} > ymax_raw) ymax_raw = {1'b0, ay};
      if ({1'b0, by} > ymax_raw) ymax_raw = {1'b0, by};
      if ({1'b0, cy} > ymax_raw) ymax_raw = {1'b0, cy};
      xmax = (xmax_raw > SW) ? SW : xmax_raw;
      ymax = (ymax_raw > SH) ? SH : ymax_raw;
      box_empty = (xmin >= xmax) || (ymin >= ymax);
   end

   logic [tsbs_pkg::BOX_W-1:0] next_x, next_y;
   logic                       row_end, last_now;
   assign next_x   = {1'b0, cursor_x_ff} + 1'b1;
   assign next_y   = {1'b0, cursor_y_ff} + 1'b1;
   assign row_end  = next_x >= box_right_ff;
   assign last_now = row_end && (next_y >= box_bottom_ff);

   // --------------------------------------------- shared multiplier operands
   // Area k uses corners (U,V,W): area = (Wx-Ux)(Vy-Uy) - (Vx-Ux)(Wy-Uy)
   logic [1:0]   area_sel;
   logic [C-1:0] ux, uy, vx, vy, wx, wy;

   assign area_sel = step_ff[2:1];

   always_comb begin
      ux = cursor_x_ff;
      uy = cursor_y_ff;
      unique case (area_sel)
         tsbs_pkg::AREA_TOTAL: begin
            ux = ax; uy = ay; vx = bx; vy = by; wx = cx; wy = cy;
         end
         tsbs_pkg::AREA_W0: begin
            vx = bx; vy = by; wx = cx; wy = cy;
         end
         tsbs_pkg::AREA_W1: begin
            vx = cx; vy = cy; wx = ax; wy = ay;
         end
         tsbs_pkg::AREA_W2: begin
            vx = ax; vy = ay; wx = bx; wy = by;
         end
         default: begin
            vx = ax; vy = ay; wx = ax; wy = ay;
         end
      endcase
   end

   logic signed [tsbs_pkg::DIFF_W-1:0] diff_a, diff_b;
   always_comb begin
      if (!step_ff[0]) begin
         diff_a = $signed({1'b0, wx}) - $signed({1'b0, ux});
         diff_b = $signed({1'b0, vy}) - $signed({1'b0, uy});
      end else begin
         diff_a = $signed({1'b0, vx}) - $signed({1'b0, ux});
         diff_b = $signed({1'b0, wy}) - $signed({1'b0, uy});
      end
   end

   logic [1:0]                   term;
   logic [tsbs_pkg::QUO_W-1:0]   chan_byte;
   logic [tsbs_pkg::COL_W-1:0]   term_colour;

   assign term        = step_ff[1:0];
   assign term_colour = colour_ff[term];

   always_comb begin
      case (chan_ff)
         tsbs_pkg::CHAN_RED:   chan_byte = term_colour[7:0];
         tsbs_pkg::CHAN_GREEN: chan_byte = term_colour[15:8];
         default:              chan_byte = term_colour[23:16];
      endcase
   end

   logic signed [tsbs_pkg::MULA_W-1:0]                 mul_a;
   logic signed [tsbs_pkg::MULB_W-1:0]                 mul_b;
   logic signed [tsbs_pkg::MULA_W+tsbs_pkg::MULB_W-1:0] prod_full;
   logic signed [tsbs_pkg::ACC_W-1:0]                  prod;

   always_comb begin
      if (state_ff == tsbs_pkg::ST_MAC) begin
         mul_a = area_ff[term + 2'd1];
         mul_b = $signed({{(tsbs_pkg::MULB_W - tsbs_pkg::QUO_W){1'b0}}, chan_byte});
      end else begin
         mul_a = {{(tsbs_pkg::MULA_W - tsbs_pkg::DIFF_W){diff_a[tsbs_pkg::DIFF_W-1]}},
                  diff_a};
         mul_b = {{(tsbs_pkg::MULB_W - tsbs_pkg::DIFF_W){diff_b[tsbs_pkg::DIFF_W-1]}},
                  diff_b};
      end
   end

   assign prod_full = mul_a * mul_b;
   assign prod      = $signed(prod_full[tsbs_pkg::ACC_W-1:0]);

   // ---------------------------------------------------------- sequencer
   logic signed [tsbs_pkg::ACC_W-1:0] area_val, area_neg, area_norm;
   logic                              area_flip, div_ge, area_nonneg;
   logic [tsbs_pkg::QUO_W-1:0]        quo_next;
   logic signed [tsbs_pkg::ACC_W-1:0] mac_sum;

   assign area_val  = acc_ff - prod;
   assign area_neg  = -area_val;
   // total area is stored as a magnitude; weights are turned to match its sign
   assign area_flip = (area_sel == tsbs_pkg::AREA_TOTAL) ?
                      area_val[tsbs_pkg::ACC_W-1] : t_neg_ff;
   assign area_norm = area_flip ? area_neg : area_val;
   assign area_nonneg = !area_norm[tsbs_pkg::ACC_W-1];
   assign mac_sum  = ((step_ff == '0) ? '0 : acc_ff) + prod;
   assign div_ge   = rem_ff >= tsbs_pkg::NUM_W'(dsr_ff);
   assign quo_next = {quo_ff[tsbs_pkg::QUO_W-2:0], div_ge};

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      chan_in       = chan_ff;
      active_in     = active_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      box_left_in   = box_left_ff;
      box_right_in  = box_right_ff;
      box_bottom_in = box_bottom_ff;
      rsp_valid_in  = rsp_valid_ff;
      pix_ok_in     = pix_ok_ff;
      cov_in        = cov_ff;
      t_neg_in      = t_neg_ff;
      acc_in        = acc_ff;
      area_in       = area_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      quo_in        = quo_ff;
      shade_in      = shade_ff;
      res_valid_in  = res_valid_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_cov_in    = res_cov_ff;
      res_col_in    = res_col_ff;
      res_last_in   = res_last_ff;
      req_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         tsbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               step_in = '0;
               if (req_restart) begin
                  if (box_empty) begin
                     active_in = 1'b0;
                     pix_ok_in = 1'b0;
                     state_in  = tsbs_pkg::ST_FINISH;
                  end else begin
                     box_left_in   = xmin[C-1:0];
                     box_right_in  = xmax;
                     box_bottom_in = ymax;
                     cursor_x_in   = xmin[C-1:0];
                     cursor_y_in   = ymin[C-1:0];
                     active_in     = 1'b1;
                     pix_ok_in     = 1'b1;
                     state_in      = tsbs_pkg::ST_AREA;
                  end
               end else if (!active_ff) begin
                  pix_ok_in = 1'b0;
                  state_in  = tsbs_pkg::ST_FINISH;
               end else begin
                  if (row_end) begin
                     cursor_x_in = box_left_ff;
                     cursor_y_in = next_y[C-1:0];
                  end else begin
                     cursor_x_in = next_x[C-1:0];
                  end
                  pix_ok_in = 1'b1;
                  state_in  = tsbs_pkg::ST_AREA;
               end
            end
         end

         tsbs_pkg::ST_AREA: begin
            step_in = step_ff + 1'b1;
            if (!step_ff[0]) begin
               acc_in = prod;
            end else begin
               area_in[area_sel] = area_norm[tsbs_pkg::AREA_W-1:0];
               if (area_sel == tsbs_pkg::AREA_TOTAL) t_neg_in = area_val[tsbs_pkg::ACC_W-1];
               if (area_sel == tsbs_pkg::AREA_W2) begin
                  // the last weight is checked as it is written
                  cov_in = (area_ff[tsbs_pkg::AREA_TOTAL] != '0)
                         && !area_ff[tsbs_pkg::AREA_W0][tsbs_pkg::AREA_W-1]
                         && !area_ff[tsbs_pkg::AREA_W1][tsbs_pkg::AREA_W-1]
                         && area_nonneg;
                  chan_in  = tsbs_pkg::CHAN_RED;
                  state_in = cov_in ? tsbs_pkg::ST_MAC : tsbs_pkg::ST_FINISH;
               end
            end
         end

         tsbs_pkg::ST_MAC: begin
            acc_in  = mac_sum;
            step_in = step_ff + 1'b1;
            if (term == 2'd2) begin
               rem_in   = mac_sum[tsbs_pkg::NUM_W-1:0];
               dsr_in   = {area_ff[tsbs_pkg::AREA_TOTAL][tsbs_pkg::DEN_W-1:0],
                           {(tsbs_pkg::QUO_W-1){1'b0}}};
               quo_in   = '0;
               step_in  = '0;
               state_in = tsbs_pkg::ST_DIV;
            end
         end

         tsbs_pkg::ST_DIV: begin
            if (div_ge) rem_in = rem_ff - tsbs_pkg::NUM_W'(dsr_ff);
            quo_in  = quo_next;
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               case (chan_ff)
                  tsbs_pkg::CHAN_RED:   shade_in[7:0]   = quo_next;
                  tsbs_pkg::CHAN_GREEN: shade_in[15:8]  = quo_next;
                  default:              shade_in[23:16] = quo_next;
               endcase
               if (chan_ff == tsbs_pkg::CHAN_BLUE) begin
                  state_in = tsbs_pkg::ST_FINISH;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = tsbs_pkg::ST_MAC;
               end
            end
         end

         tsbs_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = tsbs_pkg::ST_IDLE;
               if (pix_ok_ff) begin
                  res_valid_in = 1'b1;
                  res_x_in     = cursor_x_ff;
                  res_y_in     = cursor_y_ff;
                  res_cov_in   = cov_ff;
                  res_col_in   = cov_ff ? {1'b1, shade_ff} : '0;
                  res_last_in  = last_now;
                  if (last_now) active_in = 1'b0;
               end else begin
                  res_valid_in = 1'b0;
                  res_x_in     = '0;
                  res_y_in     = '0;
                  res_cov_in   = 1'b0;
                  res_col_in   = '0;
                  res_last_in  = 1'b0;
               end
            end
         end

         default: state_in = tsbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsbs_pkg::ST_IDLE;
         step_ff       <= '0;
         chan_ff       <= '0;
         active_ff     <= 1'b0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         box_left_ff   <= '0;
         box_right_ff  <= '0;
         box_bottom_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         chan_ff       <= chan_in;
         active_ff     <= active_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         box_left_ff   <= box_left_in;
         box_right_ff  <= box_right_in;
         box_bottom_ff <= box_bottom_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ok_ff    <= pix_ok_in;
      cov_ff       <= cov_in;
      t_neg_ff     <= t_neg_in;
      acc_ff       <= acc_in;
      area_ff      <= area_in;
      rem_ff       <= rem_in;
      dsr_ff       <= dsr_in;
      quo_ff       <= quo_in;
      shade_ff     <= shade_in;
      res_valid_ff <= res_valid_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_cov_ff   <= res_cov_in;
      res_col_ff   <= res_col_in;
      res_last_ff  <= res_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_valid_res    = res_valid_ff;
   assign rsp_pixel_x      = res_x_ff;
   assign rsp_pixel_y      = res_y_ff;
   assign rsp_covered      = res_cov_ff;
   assign rsp_pixel_colour = res_col_ff;
   assign rsp_last         = res_last_ff;

   // ---------------------------------------------------------- assertions
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == tsbs_pkg::ST_DIV |-> {1'b0, rem_ff} < {1'b0, dsr_ff, 1'b0})
      else $error("divider remainder out of range");

   a_cov_implies_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_covered |-> rsp_valid_res && rsp_pixel_colour[24])
      else $error("covered pixel without valid result or alpha");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         rsp_pixel_x == '0 && rsp_pixel_y == '0 && !rsp_last && rsp_pixel_colour == '0)
      else $error("invalid result carries nonzero fields");

   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_restart && !active_ff |=>
         state_ff == tsbs_pkg::ST_FINISH)
      else $error("advance with no scan started a computation");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the triangle scan and barycentric shade block.
`timescale 1ns / 1ps
module tb_top;

   localparam int SCREEN_W = 1024;
   localparam int SCREEN_H = 1024;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned ITEM_TARGET = 1800;
   localparam int unsigned DRAIN_CYCLES = 100;

   localparam bit CMD_ADVANCE = 1'b0;
   localparam bit CMD_RESTART = 1'b1;

   // Indexes past the register list; writes there must be ignored
   localparam logic [tsbs_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [tsbs_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                          valid_res;
      logic [tsbs_pkg::COORD_W-1:0]  pixel_x;
      logic [tsbs_pkg::COORD_W-1:0]  pixel_y;
      logic                          covered;
      logic [tsbs_pkg::PIXCOL_W-1:0] pixel_colour;
      logic                          last;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_valid_res;
   logic [tsbs_pkg::COORD_W-1:0] rsp_pixel_x;
   logic [tsbs_pkg::COORD_W-1:0] rsp_pixel_y;
   logic rsp_covered;
   logic [tsbs_pkg::PIXCOL_W-1:0] rsp_pixel_colour;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [tsbs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tsbs_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   triangle_scan_barycentric_shade_top #(
      .SCREEN_WIDTH(SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_valid_res(rsp_valid_res),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_covered(rsp_covered),
      .rsp_pixel_colour(rsp_pixel_colour),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Shadow of the block's registers and scan state
   logic [tsbs_pkg::VTX_W-1:0]   vertex_q [3] = '{default: '0};
   logic [tsbs_pkg::COL_W-1:0]   colour_q [3] = '{default: '0};
   logic [tsbs_pkg::COORD_W-1:0] cur_x = '0;
   logic [tsbs_pkg::COORD_W-1:0] cur_y = '0;
   logic [tsbs_pkg::COORD_W-1:0] box_left = '0;
   logic [tsbs_pkg::BOX_W-1:0]   box_right = '0;
   logic [tsbs_pkg::BOX_W-1:0]   box_bottom = '0;
   bit                           scan_on = 1'b0;

   bit               pending_cmds [$];
   pixel_result_type expected_pixels [$];
   int unsigned      items_queued = 0;
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;
   int unsigned      send_hold = 0;
   int unsigned      ready_hold = 0;
   bit               send_idle_on = 1'b1;
   bit               recv_idle_on = 1'b1;
   pixel_result_type oldest_pixel;

   function automatic longint edge_area(longint ux, longint uy, longint p1x, longint p1y,
                                        longint p2x, longint p2y);
      return (p1x - ux) * (p1y + uy) + (p2x - p1x) * (p1y + p2y) + (ux - p2x) * (uy + p2y);
   endfunction

   // Coverage test and interpolated colour of the pixel under the cursor
   function automatic pixel_result_type shade_pixel();
      pixel_result_type r;
      longint xs [3];
      longint ys [3];
      longint w [3];
      longint px, py, total, num, den, q;
      bit hit;
      for (int i = 0; i < 3; i++) begin
         xs[i] = longint'(vertex_q[i][tsbs_pkg::COORD_W-1:0]);
         ys[i] = longint'(vertex_q[i][tsbs_pkg::VTX_W-1:tsbs_pkg::COORD_W]);
      end
      px = longint'(cur_x);
      py = longint'(cur_y);
      total = edge_area(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]);
      w[0] = edge_area(px, py, xs[1], ys[1], xs[2], ys[2]);
      w[1] = edge_area(px, py, xs[2], ys[2], xs[0], ys[0]);
      w[2] = edge_area(px, py, xs[0], ys[0], xs[1], ys[1]);
      hit = (total != 0);
      for (int i = 0; i < 3; i++) begin
         if ((total > 0 && w[i] < 0) || (total < 0 && w[i] > 0)) hit = 1'b0;
      end
      r = '0;
      r.valid_res = 1'b1;
      r.pixel_x = cur_x;
      r.pixel_y = cur_y;
      r.covered = hit;
      if (hit) begin
         den = (total < 0) ? -total : total;
         r.pixel_colour[24] = 1'b1;
         for (int ch = 0; ch < 3; ch++) begin
            num = 0;
            for (int i = 0; i < 3; i++) num += longint'(colour_q[i][8*ch +: 8]) * w[i];
            if (total < 0) num = -num;
            if (num < 0) num = 0;
            q = num / den;
            if (q > 255) q = 255;
            r.pixel_colour[8*ch +: 8] = q[7:0];
         end
      end
      r.last = ({1'b0, cur_x} + 1'b1 >= box_right) && ({1'b0, cur_y} + 1'b1 >= box_bottom);
      if (r.last) scan_on = 1'b0;
      return r;
   endfunction

   // Expected result of one request; updates the shadow scan state
   function automatic pixel_result_type scan_step(bit restart);
      pixel_result_type r;
      longint xmin, ymin, xmax, ymax, x, y;
      r = '0;
      if (restart) begin
         xmin = longint'(SCREEN_W);
         ymin = longint'(SCREEN_H);
         xmax = 0;
         ymax = 0;
         for (int i = 0; i < 3; i++) begin
            x = longint'(vertex_q[i][tsbs_pkg::COORD_W-1:0]);
            y = longint'(vertex_q[i][tsbs_pkg::VTX_W-1:tsbs_pkg::COORD_W]);
            if (x < xmin) xmin = x;
            if (y < ymin) ymin = y;
            if (x > xmax) xmax = x;
            if (y > ymax) ymax = y;
         end
         if (xmax > longint'(SCREEN_W)) xmax = longint'(SCREEN_W);
         if (ymax > longint'(SCREEN_H)) ymax = longint'(SCREEN_H);
         if (xmin >= xmax || ymin >= ymax) begin
            scan_on = 1'b0;
            return r;
         end
         box_left = tsbs_pkg::COORD_W'(xmin);
         box_right = tsbs_pkg::BOX_W'(xmax);
         box_bottom = tsbs_pkg::BOX_W'(ymax);
         cur_x = tsbs_pkg::COORD_W'(xmin);
         cur_y = tsbs_pkg::COORD_W'(ymin);
         scan_on = 1'b1;
         return shade_pixel();
      end
      if (!scan_on) return r;
      if ({1'b0, cur_x} + 1'b1 >= box_right) begin
         cur_x = box_left;
         cur_y = cur_y + 1'b1;
      end else begin
         cur_x = cur_x + 1'b1;
      end
      return shade_pixel();
   endfunction

   function automatic int unsigned draw_pause(bit idle_on);
      return idle_on ? $urandom_range(0, 14) : 0;
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(scan_step(req_restart));
            send_hold = draw_pause(send_idle_on);
         end
         if (!req_valid || req_ready) begin
            if (send_hold != 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               req_valid <= 1'b1;
               req_restart <= pending_cmds.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("rsp transaction with no request outstanding");
            mismatches++;
         end else begin
            oldest_pixel = expected_pixels.pop_front();
            check_field("valid_res", 64'(oldest_pixel.valid_res), 64'(rsp_valid_res));
            check_field("pixel_x", 64'(oldest_pixel.pixel_x), 64'(rsp_pixel_x));
            check_field("pixel_y", 64'(oldest_pixel.pixel_y), 64'(rsp_pixel_y));
            check_field("covered", 64'(oldest_pixel.covered), 64'(rsp_covered));
            check_field("pixel_colour", 64'(oldest_pixel.pixel_colour),
                        64'(rsp_pixel_colour));
            check_field("last", 64'(oldest_pixel.last), 64'(rsp_last));
         end
         ready_hold = draw_pause(recv_idle_on);
         rsp_ready <= (ready_hold == 0);
      end else if (ready_hold != 0) begin
         ready_hold--;
         rsp_ready <= (ready_hold == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic queue_item(bit cmd);
      pending_cmds.push_back(cmd);
      items_queued++;
   endtask

   // Hold the stimulus until every transaction has come back
   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(logic [tsbs_pkg::CSR_IDX_W-1:0] idx,
                            logic [tsbs_pkg::CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx <= tsbs_pkg::REG_VERTEX_C) vertex_q[idx[1:0]] = data[tsbs_pkg::VTX_W-1:0];
      else if (idx <= tsbs_pkg::REG_COLOUR_C) colour_q[2'(idx - tsbs_pkg::REG_COLOUR_A)] = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Upper data bits are junk; the block must mask them off
   task automatic write_vertex(logic [tsbs_pkg::CSR_IDX_W-1:0] idx,
                               logic [tsbs_pkg::COORD_W-1:0] x,
                               logic [tsbs_pkg::COORD_W-1:0] y);
      logic [1:0] junk;
      junk = 2'($urandom_range(0, 3));
      write_reg(idx, {junk, y, x});
   endtask

   task automatic set_triangle(logic [tsbs_pkg::COORD_W-1:0] ax, logic [tsbs_pkg::COORD_W-1:0] ay,
                               logic [tsbs_pkg::COORD_W-1:0] bx, logic [tsbs_pkg::COORD_W-1:0] by,
                               logic [tsbs_pkg::COORD_W-1:0] cx, logic [tsbs_pkg::COORD_W-1:0] cy);
      write_vertex(tsbs_pkg::REG_VERTEX_A, ax, ay);
      write_vertex(tsbs_pkg::REG_VERTEX_B, bx, by);
      write_vertex(tsbs_pkg::REG_VERTEX_C, cx, cy);
   endtask

   function automatic int pick_base();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 8);
         1: return $urandom_range(1012, 1024);
         2: return $urandom_range(0, 2040);
         default: return 2040;
      endcase
   endfunction

   function automatic logic [tsbs_pkg::COL_W-1:0] pick_colour();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return tsbs_pkg::COL_W'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   initial begin : stimulus
      int base_x, base_y, kind, roll;
      logic [tsbs_pkg::COORD_W-1:0] corner_x [3];
      logic [tsbs_pkg::COORD_W-1:0] corner_y [3];
      while (reset) @(negedge clock);

      // Advance before any scan, then restart on an all-zero triangle (empty box)
      queue_item(CMD_ADVANCE);
      queue_item(CMD_RESTART);
      drain();

      // Tiny box scanned to its last pixel and one step past it
      set_triangle(0, 0, 2, 0, 0, 2);
      write_reg(tsbs_pkg::REG_COLOUR_A, 24'h0000FF);
      write_reg(tsbs_pkg::REG_COLOUR_B, 24'h00FF00);
      write_reg(tsbs_pkg::REG_COLOUR_C, 24'hFF0000);
      write_reg(REG_SPARE_LO, 24'hFFFFFF);
      queue_item(CMD_RESTART);
      repeat (4) queue_item(CMD_ADVANCE);
      drain();

      // Collinear vertices: zero area covers nothing
      set_triangle(3, 3, 5, 5, 7, 7);
      queue_item(CMD_RESTART);
      repeat (2) queue_item(CMD_ADVANCE);
      drain();

      // Extreme coordinates, box clamped at the screen corner, white vertices
      set_triangle(2047, 2047, 1020, 1021, 2047, 1022);
      write_reg(tsbs_pkg::REG_COLOUR_A, 24'hFFFFFF);
      write_reg(tsbs_pkg::REG_COLOUR_B, 24'hFFFFFF);
      write_reg(tsbs_pkg::REG_COLOUR_C, 24'hFFFFFF);
      write_reg(REG_SPARE_HI, 24'h123456);
      queue_item(CMD_RESTART);
      repeat (2) queue_item(CMD_ADVANCE);
      drain();

      // Whole triangle right of the screen: empty box
      set_triangle(1500, 10, 1600, 20, 2000, 30);
      queue_item(CMD_RESTART);
      queue_item(CMD_ADVANCE);
      drain();

      // Change registers in the middle of a scan
      set_triangle(0, 0, 0, 4, 4, 0);
      write_reg(tsbs_pkg::REG_COLOUR_A, 24'h000000);
      queue_item(CMD_RESTART);
      repeat (2) queue_item(CMD_ADVANCE);
      drain();
      write_reg(tsbs_pkg::REG_COLOUR_A, 24'h80C040);
      write_vertex(tsbs_pkg::REG_VERTEX_C, 6, 1);
      repeat (2) queue_item(CMD_ADVANCE);

      while (items_queued < ITEM_TARGET) begin
         drain();
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         base_x = pick_base();
         base_y = pick_base();
         for (int i = 0; i < 3; i++) begin
            if (kind == 0) begin
               corner_x[i] = tsbs_pkg::COORD_W'($urandom_range(0, 2047));
               corner_y[i] = tsbs_pkg::COORD_W'($urandom_range(0, 2047));
            end else begin
               corner_x[i] = tsbs_pkg::COORD_W'(base_x + $urandom_range(0, 7));
               corner_y[i] = tsbs_pkg::COORD_W'(base_y + $urandom_range(0, 7));
            end
         end
         if (kind == 1) begin
            corner_x[2] = corner_x[0];
            corner_y[2] = corner_y[0];
         end
         // Skipped writes keep the old values, which may belong to a running scan
         for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 3) != 0)
               write_vertex(tsbs_pkg::CSR_IDX_W'(i), corner_x[i], corner_y[i]);
            if ($urandom_range(0, 3) != 0)
               write_reg(tsbs_pkg::CSR_IDX_W'(tsbs_pkg::REG_COLOUR_A + i), pick_colour());
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(tsbs_pkg::CSR_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      tsbs_pkg::CSR_DAT_W'($urandom_range(0, 24'hFFFFFF)));
         roll = $urandom_range(0, 19);
         if (roll < 3) begin
            repeat ($urandom_range(1, 8)) queue_item(1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 4) != 0) queue_item(CMD_RESTART);
            repeat ($urandom_range(0, (kind == 0) ? 12 : 55)) queue_item(CMD_ADVANCE);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule
